>>> sv/pba_pkg.sv
// Shared types and constants for the page bitmap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package pba_pkg;

  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PNUM_W     = ADDR_W - PAGE_SHIFT;
  localparam int MAP_W      = 32;
  localparam int BIT_W      = 5;

  typedef enum logic [2:0] {
    CMD_ALLOC     = 3'd0,
    CMD_RELEASE   = 3'd1,
    CMD_MARK_USED = 3'd2,
    CMD_MARK_FREE = 3'd3,
    CMD_MARK_ALL  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_WAS_FREE = 2'd2,
    ST_BEYOND   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_REL_RD,
    S_REL_WR,
    S_RNG_RD,
    S_RNG_WR,
    S_FILL,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    WI_HOLD,
    WI_ZERO,
    WI_CURSOR,
    WI_FIRST,
    WI_INC
  } widx_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ONES,
    WR_HIT,
    WR_REL,
    WR_SET,
    WR_CLR
  } wr_sel_t;

  typedef struct packed {
    logic     load;
    widx_op_t widx_op;
    logic     rd_en;
    wr_sel_t  wr_sel;
    logic     mask_cursor;
    logic     cur_zero;
    logic     res_load;
    status_t  res_status;
    logic     res_hit;
  } ctrl_t;

  typedef struct packed {
    logic hit;
    logic last_word;
    logic range_last;
    logic cursor_at_end;
    logic cursor_zero;
    logic beyond;
    logic size_zero;
    logic rel_used;
  } dp_stat_t;

endpackage

>>> sv/pba_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; used for the page bitmap.
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/pba_datapath.sv
// Datapath of the page bitmap allocator: bitmap RAM, word index, cursor,
// range bounds, free-bit search and result registers. Depends on pba_pkg and pba_ram.
module pba_datapath import pba_pkg::*; #(
  parameter int NUM_PAGES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [ADDR_W-1:0]  size,
  input  ctrl_t              ctrl,
  output dp_stat_t           stat,
  output logic [ADDR_W-1:0]  page_addr,
  output logic [1:0]         status
);

  localparam int MAP_WORDS = (NUM_PAGES + MAP_W - 1) / MAP_W;
  localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW = $clog2(NUM_PAGES + 1);
  localparam int EW = PNUM_W + 1;
  localparam logic [EW-1:0] NUM_PAGES_E = EW'(NUM_PAGES);
  localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);

  logic [WW-1:0]        widx;
  logic [PW-1:0]        cursor;
  logic [PNUM_W-1:0]    first_page;
  logic [ADDR_W:0]      end_sum;
  logic                 size_zero;
  logic [PW-1:0]        stop_page;
  logic [WW-1:0]        end_word;
  logic [WW+BIT_W-1:0]  hit_page;
  logic [ADDR_W-1:0]    page_addr_r;
  status_t              status_r;

  logic [MAP_W-1:0]     rdata;
  logic [MAP_W-1:0]     wdata;
  logic                 we;
  logic [MAP_W-1:0]     free_bits;
  logic [MAP_W-1:0]     cur_mask;
  logic [MAP_W-1:0]     lo_mask;
  logic [MAP_W-1:0]     hi_mask;
  logic [MAP_W-1:0]     rng_mask;
  logic [BIT_W-1:0]     enc;
  logic [WW+BIT_W-1:0]  hit_idx;
  logic [EW-1:0]        cur_ext;
  logic [EW-1:0]        end_ext;
  logic [EW-1:0]        end_last;
  logic [EW:0]          end_raw;
  logic [WW-1:0]        cur_word;
  logic [WW-1:0]        first_word;
  logic [BIT_W-1:0]     first_bit;

  function automatic logic [BIT_W-1:0] first_one(input logic [MAP_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  assign cur_ext    = EW'(cursor);
  assign end_ext    = EW'(stop_page);
  assign end_last   = end_ext - EW'(1);
  assign cur_word   = cur_ext[WW+BIT_W-1:BIT_W];
  assign first_word = first_page[WW+BIT_W-1:BIT_W];
  assign first_bit  = first_page[BIT_W-1:0];
  assign end_raw    = {1'b0, end_sum[ADDR_W:PAGE_SHIFT]}
                    + (EW+1)'(|end_sum[PAGE_SHIFT-1:0]);

  always_comb begin
    cur_mask = '1;
    if (ctrl.mask_cursor && (widx == cur_word)) begin
      cur_mask = '1 << cur_ext[BIT_W-1:0];
    end
    free_bits = ~rdata & cur_mask;
    enc       = first_one(free_bits);
    hit_idx   = {widx, enc};

    lo_mask = '1;
    if (widx == first_word) begin
      lo_mask = '1 << first_bit;
    end
    hi_mask = '1;
    if ((widx == end_word) && (end_ext[BIT_W-1:0] != '0)) begin
      hi_mask = (MAP_W'(1) << end_ext[BIT_W-1:0]) - MAP_W'(1);
    end
    rng_mask = lo_mask & hi_mask;

    we    = 1'b1;
    wdata = rdata;
    case (ctrl.wr_sel)
      WR_ONES: wdata = '1;
      WR_HIT:  wdata = rdata | (MAP_W'(1) << enc);
      WR_REL:  wdata = rdata & ~(MAP_W'(1) << first_bit);
      WR_SET:  wdata = rdata | rng_mask;
      WR_CLR:  wdata = rdata & ~rng_mask;
      default: we = 1'b0;
    endcase
  end

  pba_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (widx),
    .wdata (wdata),
    .re    (ctrl.rd_en),
    .raddr (widx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      widx   <= '0;
      cursor <= '0;
    end else begin
      case (ctrl.widx_op)
        WI_ZERO:   widx <= '0;
        WI_CURSOR: widx <= cur_word;
        WI_FIRST:  widx <= first_word;
        WI_INC:    widx <= widx + WW'(1);
        default:   widx <= widx;
      endcase
      if (ctrl.wr_sel == WR_HIT) begin
        cursor <= PW'(EW'(hit_idx) + EW'(1));
      end else if (ctrl.cur_zero) begin
        cursor <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      first_page <= addr[ADDR_W-1:PAGE_SHIFT];
      end_sum    <= {1'b0, addr} + {1'b0, size};
      size_zero  <= (size == '0);
    end
    if (end_raw > {1'b0, NUM_PAGES_E}) begin
      stop_page <= PW'(NUM_PAGES);
    end else begin
      stop_page <= end_raw[PW-1:0];
    end
    end_word <= end_last[WW+BIT_W-1:BIT_W];
    if (ctrl.wr_sel == WR_HIT) begin
      hit_page <= hit_idx;
    end
    if (ctrl.res_load) begin
      status_r    <= ctrl.res_status;
      page_addr_r <= ctrl.res_hit ? (ADDR_W'(hit_page) << PAGE_SHIFT) : '0;
    end
  end

  assign stat.hit           = |free_bits;
  assign stat.last_word     = (widx == LAST_WORD);
  assign stat.range_last    = (widx == end_word);
  assign stat.cursor_at_end = (cur_ext == NUM_PAGES_E);
  assign stat.cursor_zero   = (cursor == '0);
  assign stat.beyond        = ({1'b0, first_page} >= NUM_PAGES_E);
  assign stat.size_zero     = size_zero;
  assign stat.rel_used      = rdata[first_bit];

  assign page_addr = page_addr_r;
  assign status    = status_r;

endmodule

>>> sv/pba_ctrl.sv
// Controller state machine of the page bitmap allocator: request and response
// handshakes, command sequencing and result status. Depends on pba_pkg.
module pba_ctrl import pba_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [2:0] cmd,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output ctrl_t      ctrl,
  input  dp_stat_t   stat
);

  state_t     state, state_next;
  logic [2:0] cmd_q;
  logic       wrapped, wrapped_next;
  status_t    pend_status, pend_status_next;
  logic       pend_hit, pend_hit_next;
  logic       rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      wrapped   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wrapped   <= wrapped_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= cmd;
    end
    pend_status <= pend_status_next;
    pend_hit    <= pend_hit_next;
  end

  always_comb begin
    state_next         = state;
    wrapped_next       = wrapped;
    pend_status_next   = pend_status;
    pend_hit_next      = pend_hit;
    req_stall          = 1'b1;
    ctrl.load          = 1'b0;
    ctrl.widx_op       = WI_HOLD;
    ctrl.rd_en         = 1'b0;
    ctrl.wr_sel        = WR_NONE;
    ctrl.mask_cursor   = 1'b0;
    ctrl.cur_zero      = 1'b0;
    ctrl.res_load      = 1'b0;
    ctrl.res_status    = pend_status;
    ctrl.res_hit       = pend_hit;

    unique case (state)
      S_INIT: begin
        ctrl.wr_sel  = WR_ONES;
        ctrl.widx_op = WI_INC;
        if (stat.last_word) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_stall    = 1'b0;
        ctrl.widx_op = WI_ZERO;
        if (req_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        pend_status_next = ST_OK;
        pend_hit_next    = 1'b0;
        unique case (cmd_q)
          CMD_ALLOC: begin
            state_next = S_ALLOC_RD;
            if (stat.cursor_at_end) begin
              wrapped_next = 1'b1;
              ctrl.widx_op = WI_ZERO;
            end else begin
              wrapped_next = 1'b0;
              ctrl.widx_op = WI_CURSOR;
            end
          end
          CMD_RELEASE: begin
            if (stat.beyond) begin
              pend_status_next = ST_BEYOND;
              state_next       = S_DONE;
            end else begin
              ctrl.widx_op = WI_FIRST;
              state_next   = S_REL_RD;
            end
          end
          CMD_MARK_USED, CMD_MARK_FREE: begin
            if (stat.beyond) begin
              pend_status_next = ST_BEYOND;
              state_next       = S_DONE;
            end else if (stat.size_zero) begin
              state_next = S_DONE;
            end else begin
              ctrl.widx_op = WI_FIRST;
              state_next   = S_RNG_RD;
            end
          end
          CMD_MARK_ALL: begin
            ctrl.widx_op = WI_ZERO;
            state_next   = S_FILL;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_ALLOC_RD: begin
        ctrl.rd_en = 1'b1;
        state_next = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        ctrl.mask_cursor = !wrapped;
        if (stat.hit) begin
          ctrl.wr_sel   = WR_HIT;
          pend_hit_next = 1'b1;
          state_next    = S_DONE;
        end else if (stat.last_word) begin
          if (!wrapped && !stat.cursor_zero) begin
            wrapped_next = 1'b1;
            ctrl.widx_op = WI_ZERO;
            state_next   = S_ALLOC_RD;
          end else begin
            ctrl.cur_zero    = 1'b1;
            pend_status_next = ST_OOM;
            state_next       = S_DONE;
          end
        end else begin
          ctrl.widx_op = WI_INC;
          state_next   = S_ALLOC_RD;
        end
      end
      S_REL_RD: begin
        ctrl.rd_en = 1'b1;
        state_next = S_REL_WR;
      end
      S_REL_WR: begin
        ctrl.wr_sel      = WR_REL;
        pend_status_next = stat.rel_used ? ST_OK : ST_WAS_FREE;
        state_next       = S_DONE;
      end
      S_RNG_RD: begin
        ctrl.rd_en = 1'b1;
        state_next = S_RNG_WR;
      end
      S_RNG_WR: begin
        ctrl.wr_sel = (cmd_q == CMD_MARK_USED) ? WR_SET : WR_CLR;
        if (stat.range_last) begin
          state_next = S_DONE;
        end else begin
          ctrl.widx_op = WI_INC;
          state_next   = S_RNG_RD;
        end
      end
      S_FILL: begin
        ctrl.wr_sel  = WR_ONES;
        ctrl.widx_op = WI_INC;
        if (stat.last_word) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          ctrl.res_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    rsp_valid_next = ctrl.res_load || (rsp_valid && rsp_stall);
  end

endmodule

>>> sv/page_bitmap_allocator.sv
// Page frame allocator with one used bit per 4 KiB page and a next-fit cursor.
// Top level; depends on pba_pkg, pba_ctrl and pba_datapath.
//
// The bitmap lives in a RAM of 32-bit words that is walked one word at a time
// (read, then check or write back), so the cost of a command is set by that
// single RAM port. After reset the block fills every word with ones before it
// takes its first request. Allocate scans words from the cursor word (plus the
// words rescanned from page zero when the search wraps). Release reads and
// writes back one word, a range mark walks the words the range touches, and
// mark-all-used fills every word. Commands that fail a check skip the bitmap.
// A new request is taken while the previous response still waits.
module page_bitmap_allocator import pba_pkg::*; #(
  parameter int NUM_PAGES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [2:0]        cmd,
  input  logic [ADDR_W-1:0] addr,
  input  logic [ADDR_W-1:0] size,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [ADDR_W-1:0] page_addr,
  output logic [1:0]        status
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  pba_datapath #(
    .NUM_PAGES (NUM_PAGES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .addr      (addr),
    .size      (size),
    .ctrl      (ctrl),
    .stat      (stat),
    .page_addr (page_addr),
    .status    (status)
  );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for page_bitmap_allocator: directed and random page commands
// are checked against a bitmap and next-fit cursor kept inside the bench.
// Depends on pba_pkg and the page_bitmap_allocator RTL.
module testbench;
  import pba_pkg::*;

  localparam int NUM_PAGES = 4096;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
  localparam logic [ADDR_W-1:0] OFFSET_MASK = PAGE_BYTES - 1;
  localparam int IDLE_PCT = 17;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_ITEMS = 520;
  localparam int unsigned LIMIT_CYCLES = 1500000;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0] page_addr;
    status_t           status;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [2:0]        cmd = CMD_ALLOC;
  logic [ADDR_W-1:0] addr = '0;
  logic [ADDR_W-1:0] size = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic [ADDR_W-1:0] page_addr;
  logic [1:0]        status;

  bit          used_map [NUM_PAGES];
  int unsigned alloc_cursor = 0;
  int unsigned granted_pages[$];
  reply_t      awaited_replies[$];
  reply_t      want;
  int          errors = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  int          hold_gen = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  page_bitmap_allocator #(.NUM_PAGES(NUM_PAGES)) DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // A hold-off request keeps the reply side stalled while a counter loaded from HOLD_CYCLES runs down.
  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (calm) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 100) $display("[cycle %0d] mismatch: %s", cycle_count, what);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("reply with nothing awaited: page_addr %h status %0d",
                                  page_addr, status));
      end else begin
        want = awaited_replies.pop_front();
        if (page_addr !== want.page_addr)
          report_mismatch($sformatf("page_addr %h, expected %h", page_addr, want.page_addr));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      end
    end
  end

  function automatic int find_free(int unsigned from);
    for (int unsigned p = from; p < NUM_PAGES; p++)
      if (!used_map[p]) return p;
    return -1;
  endfunction

  function automatic status_t mark_span(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] s, bit val);
    logic [ADDR_W:0]   end_byte;
    longint unsigned   first_pg;
    longint unsigned   end_pg;
    first_pg = a >> PAGE_SHIFT;
    if (first_pg >= NUM_PAGES) return ST_BEYOND;
    if (s == 0) return ST_OK;
    end_byte = {1'b0, a} + {1'b0, s};
    end_pg = (end_byte >> PAGE_SHIFT) + ((end_byte & OFFSET_MASK) != 0);
    if (end_pg > NUM_PAGES) end_pg = NUM_PAGES;
    for (longint unsigned p = first_pg; p < end_pg; p++) used_map[p] = val;
    return ST_OK;
  endfunction

  function automatic reply_t apply_page_cmd(logic [2:0] c, logic [ADDR_W-1:0] a,
                                            logic [ADDR_W-1:0] s);
    reply_t      r;
    int          hit;
    int unsigned pg;
    r.page_addr = '0;
    r.status = ST_OK;
    pg = a >> PAGE_SHIFT;
    case (c)
      CMD_ALLOC: begin
        hit = find_free(alloc_cursor);
        if (hit < 0 && alloc_cursor != 0) begin
          alloc_cursor = 0;
          hit = find_free(0);
        end
        if (hit >= 0) begin
          used_map[hit] = 1'b1;
          alloc_cursor = hit + 1;
          r.page_addr = hit << PAGE_SHIFT;
          granted_pages.push_back(hit);
        end else begin
          r.status = ST_OOM;
        end
      end
      CMD_RELEASE: begin
        if (pg >= NUM_PAGES) begin
          r.status = ST_BEYOND;
        end else begin
          r.status = used_map[pg] ? ST_OK : ST_WAS_FREE;
          used_map[pg] = 1'b0;
        end
      end
      CMD_MARK_USED: r.status = mark_span(a, s, 1'b1);
      CMD_MARK_FREE: r.status = mark_span(a, s, 1'b0);
      CMD_MARK_ALL: foreach (used_map[i]) used_map[i] = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  // Offers one command and records its expected reply once the transfer happens.
  task automatic issue_cmd(input logic [2:0] c, input logic [ADDR_W-1:0] a,
                           input logic [ADDR_W-1:0] s);
    int gap;
    gap = 0;
    if (!calm)
      while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= c;
    addr <= a;
    size <= s;
    do @(posedge clk); while (req_stall);
    awaited_replies.push_back(apply_page_cmd(c, a, s));
  endtask

  function automatic logic [ADDR_W-1:0] release_target();
    int unsigned       k;
    logic [ADDR_W-1:0] a;
    a = $urandom;
    if (granted_pages.size() != 0 && $urandom_range(99) < 70) begin
      k = $urandom_range(granted_pages.size() - 1);
      a = (granted_pages[k] << PAGE_SHIFT) | (a & OFFSET_MASK);
      granted_pages.delete(k);
    end else if ($urandom_range(99) < 85) begin
      a = ($urandom_range(NUM_PAGES - 1) << PAGE_SHIFT) | (a & OFFSET_MASK);
    end
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] span_start();
    int                r;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(99);
    a = $urandom;
    if (r < 80)
      a = ($urandom_range(NUM_PAGES - 1) << PAGE_SHIFT) | (a & OFFSET_MASK);
    else if (r < 92)
      a = ($urandom_range(NUM_PAGES - 1, NUM_PAGES - 8) << PAGE_SHIFT) | (a & OFFSET_MASK);
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] span_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 70) return $urandom_range(16 * PAGE_BYTES, 1);
    if (r < 90) return $urandom_range(256 * PAGE_BYTES, 1);
    return $urandom;
  endfunction

  task automatic test_after_reset();
    issue_cmd(CMD_ALLOC, '1, '1);
    issue_cmd(CMD_RELEASE, 32'h0000_5ABC, '0);
    issue_cmd(CMD_ALLOC, '0, '0);
    issue_cmd(CMD_ALLOC, '0, '0);
    issue_cmd(CMD_RELEASE, 32'h0000_5000, '1);
    issue_cmd(CMD_RELEASE, 32'h0000_5FFF, '0);
  endtask

  task automatic test_special_cases();
    issue_cmd(CMD_RELEASE, 32'h00FF_FFFF, '0);
    issue_cmd(CMD_RELEASE, 32'h0100_0000, '0);
    issue_cmd(CMD_MARK_FREE, 32'h0100_0000, 32'h0000_1000);
    issue_cmd(CMD_MARK_USED, '1, '1);
    issue_cmd(CMD_MARK_FREE, 32'h0000_3000, '0);
    for (int k = CMD_SPARE_LO; k <= CMD_SPARE_HI; k++) issue_cmd(3'(k), '1, '1);
  endtask

  task automatic test_ranges_and_wrap();
    issue_cmd(CMD_MARK_FREE, '0, '1);
    issue_cmd(CMD_MARK_USED, '0, 32'h00FF_E000);
    issue_cmd(CMD_ALLOC, '0, '0);
    issue_cmd(CMD_ALLOC, '0, '0);
    issue_cmd(CMD_RELEASE, 32'h0000_A000, '0);
    issue_cmd(CMD_ALLOC, '0, '0);
    issue_cmd(CMD_RELEASE, 32'h00FF_E000, '0);
    issue_cmd(CMD_ALLOC, '0, '0);
    issue_cmd(CMD_ALLOC, '0, '0);
    issue_cmd(CMD_MARK_FREE, 32'h0000_5FFF, 32'h0000_0002);
    issue_cmd(CMD_ALLOC, '0, '0);
    issue_cmd(CMD_MARK_ALL, '1, '1);
    issue_cmd(CMD_ALLOC, '0, '0);
  endtask

  // The reply side holds off while commands keep coming, so the request side fills up.
  task automatic test_backpressure();
    issue_cmd(CMD_MARK_FREE, 32'h0001_0000, 32'h0004_0000);
    hold_gen <= hold_gen + 1;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) issue_cmd(CMD_RELEASE, release_target(), $urandom);
      else issue_cmd(CMD_ALLOC, $urandom, $urandom);
    end
  endtask

  task automatic test_random_traffic(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i == 150) calm <= 1'b1;
      if (i == 280) calm <= 1'b0;
      r = $urandom_range(99);
      if (r < 40) issue_cmd(CMD_ALLOC, $urandom, $urandom);
      else if (r < 62) issue_cmd(CMD_RELEASE, release_target(), $urandom);
      else if (r < 72) issue_cmd(CMD_MARK_USED, span_start(), span_length());
      else if (r < 90) issue_cmd(CMD_MARK_FREE, span_start(), span_length());
      else if (r < 93) issue_cmd(CMD_MARK_ALL, $urandom, $urandom);
      else issue_cmd(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), $urandom, $urandom);
    end
  endtask

  initial begin
    foreach (used_map[i]) used_map[i] = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_special_cases();
    test_ranges_and_wrap();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    req_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
sv/pba_pkg.sv
sv/pba_ram.sv
sv/pba_datapath.sv
sv/pba_ctrl.sv
sv/page_bitmap_allocator.sv
verif/testbench.sv
